>>> rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; expects clk and rst in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define AST_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, off during reset
`define AST_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

// next-cycle implication that also holds across reset
`define AST_ALWAYS(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

>>> rtl/ropq_pkg.sv
// shared types and constants of the rank ordered packet queue
// no dependencies
`timescale 1ns / 1ps
package ropq_pkg;
  localparam int DEPTH       = 256;
  localparam int AW          = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int HANDLE_BITS = 16;
  localparam int RANK_W      = 64;
  localparam int DEV_W       = 8;
  localparam int CAP_W       = 9;

  typedef enum logic [2:0] {
    OP_PUSH, OP_POP, OP_LOOKUP, OP_DELETE, OP_NEXT, OP_FIRST, OP_FLUSH, OP_NOP
  } op_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_MISS   = 2'd2,
    ST_NONEXT = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE, S_RD, S_EV, S_DONE
  } state_t;

  typedef struct packed {
    op_t                    op;
    logic [RANK_W-1:0]      rank;
    logic [HANDLE_BITS-1:0] handle;
    logic [DEV_W-1:0]       dev;
  } cmd_t;

  typedef struct packed {
    logic [RANK_W-1:0]      rank;
    logic [HANDLE_BITS-1:0] handle;
    logic [DEV_W-1:0]       dev;
  } entry_t;
endpackage

>>> rtl/ropq_front.sv
// front end: accepts words, decodes the operation, two-entry command queue
// depends on ropq_pkg
`timescale 1ns / 1ps
module ropq_front (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [2:0]                     mode,
  input  logic                           device_flush,
  input  logic [ropq_pkg::RANK_W-1:0]    rank,
  input  logic [15:0]                    handle,
  input  logic [ropq_pkg::DEV_W-1:0]     device_id,
  output logic                           cmd_valid,
  input  logic                           cmd_take,
  output ropq_pkg::cmd_t                 cmd
);
  ropq_pkg::cmd_t q [2];
  logic       wp, rp;
  logic [1:0] fill;
  ropq_pkg::cmd_t dec;
  logic push, pop;

  always_comb begin
    if (device_flush) begin
      dec.op = ropq_pkg::OP_FLUSH;
    end else begin
      case (mode)
        ropq_pkg::OP_PUSH:   dec.op = ropq_pkg::OP_PUSH;
        ropq_pkg::OP_POP:    dec.op = ropq_pkg::OP_POP;
        ropq_pkg::OP_LOOKUP: dec.op = ropq_pkg::OP_LOOKUP;
        ropq_pkg::OP_DELETE: dec.op = ropq_pkg::OP_DELETE;
        ropq_pkg::OP_NEXT:   dec.op = ropq_pkg::OP_NEXT;
        ropq_pkg::OP_FIRST:  dec.op = ropq_pkg::OP_FIRST;
        default:             dec.op = ropq_pkg::OP_NOP;
      endcase
    end
    dec.rank   = rank;
    dec.handle = handle[ropq_pkg::HANDLE_BITS-1:0];
    dec.dev    = device_id;
  end

  assign in_ready  = (fill != 2'd2);
  assign cmd_valid = (fill != 2'd0);
  assign cmd       = q[rp];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_take && cmd_valid;

  always_ff @(posedge clk) begin
    if (push) q[wp] <= dec;
    if (rst) begin
      wp   <= 1'b0;
      rp   <= 1'b0;
      fill <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop)  rp <= ~rp;
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

>>> rtl/ropq_back.sv
// back end: sequencer over the entry memory, capacity register, result register
// depends on ropq_pkg
`timescale 1ns / 1ps
module ropq_back (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [ropq_pkg::CAP_W-1:0]      cfg_data,
  input  logic                            cmd_valid,
  output logic                            cmd_take,
  input  ropq_pkg::cmd_t                  cmd,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      status,
  output logic [15:0]                     found_handle,
  output logic [ropq_pkg::RANK_W-1:0]     result_rank,
  output logic [8:0]                      occupancy
);
  localparam int CW = ropq_pkg::CNT_W;
  localparam int AW = ropq_pkg::AW;

  ropq_pkg::entry_t mem [ropq_pkg::DEPTH];
  ropq_pkg::entry_t rdata, wdata, new_ent;
  logic ren, we;
  logic [AW-1:0] raddr, waddr;

  ropq_pkg::state_t state, state_next;
  ropq_pkg::cmd_t   c, c_next;
  logic [CW-1:0]    i, i_next, w, w_next, cnt, cnt_next, limit;
  logic             matched, matched_next;
  logic [ropq_pkg::CAP_W-1:0] cap;
  ropq_pkg::status_t res_st, res_st_next;
  logic [ropq_pkg::HANDLE_BITS-1:0] res_fh, res_fh_next;
  logic [ropq_pkg::RANK_W-1:0]      res_rr, res_rr_next;
  logic ovalid_next, load_out;
  logic at_end, eq, gt, limit_hit, out_free;

  assign limit = (cap < ropq_pkg::CAP_W'(ropq_pkg::DEPTH)) ? CW'(cap) : CW'(ropq_pkg::DEPTH);
  assign limit_hit = (cnt >= limit);
  assign at_end    = (i == cnt);
  assign eq        = (rdata.rank == c.rank);
  assign gt        = (rdata.rank > c.rank);
  assign out_free  = !out_valid || out_ready;
  assign new_ent   = '{rank: c.rank, handle: c.handle, dev: c.dev};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ropq_pkg::S_IDLE: begin
        if (cmd_valid) begin
          case (cmd.op)
            ropq_pkg::OP_NOP:   state_next = ropq_pkg::S_DONE;
            ropq_pkg::OP_FIRST: state_next = (cnt == '0) ? ropq_pkg::S_DONE : ropq_pkg::S_RD;
            ropq_pkg::OP_PUSH:  state_next = limit_hit ? ropq_pkg::S_DONE : ropq_pkg::S_RD;
            default:            state_next = ropq_pkg::S_RD;
          endcase
        end
      end
      ropq_pkg::S_RD: begin
        case (c.op)
          ropq_pkg::OP_PUSH:  state_next = (i == '0) ? ropq_pkg::S_DONE : ropq_pkg::S_EV;
          ropq_pkg::OP_FIRST: state_next = ropq_pkg::S_EV;
          default:            state_next = at_end ? ropq_pkg::S_DONE : ropq_pkg::S_EV;
        endcase
      end
      ropq_pkg::S_EV: begin
        case (c.op)
          ropq_pkg::OP_PUSH:   state_next = gt ? ropq_pkg::S_RD : ropq_pkg::S_DONE;
          ropq_pkg::OP_FIRST:  state_next = ropq_pkg::S_DONE;
          ropq_pkg::OP_LOOKUP: state_next = eq ? ropq_pkg::S_DONE : ropq_pkg::S_RD;
          ropq_pkg::OP_NEXT:   state_next = matched ? ropq_pkg::S_DONE : ropq_pkg::S_RD;
          default:             state_next = ropq_pkg::S_RD;
        endcase
      end
      ropq_pkg::S_DONE: begin
        if (out_free) state_next = ropq_pkg::S_IDLE;
      end
      default: state_next = ropq_pkg::S_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    c_next       = c;
    i_next       = i;
    w_next       = w;
    cnt_next     = cnt;
    matched_next = matched;
    res_st_next  = res_st;
    res_fh_next  = res_fh;
    res_rr_next  = res_rr;
    cmd_take     = 1'b0;
    ren          = 1'b0;
    raddr        = '0;
    we           = 1'b0;
    waddr        = '0;
    wdata        = new_ent;
    load_out     = 1'b0;
    case (state)
      ropq_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd_take     = 1'b1;
          c_next       = cmd;
          i_next       = (cmd.op == ropq_pkg::OP_PUSH) ? cnt : '0;
          w_next       = '0;
          matched_next = 1'b0;
          res_st_next  = ropq_pkg::ST_OK;
          res_fh_next  = '0;
          res_rr_next  = '0;
          if (cmd.op == ropq_pkg::OP_FIRST && cnt == '0) res_st_next = ropq_pkg::ST_MISS;
          if (cmd.op == ropq_pkg::OP_PUSH && limit_hit)  res_st_next = ropq_pkg::ST_FULL;
        end
      end
      ropq_pkg::S_RD: begin
        case (c.op)
          ropq_pkg::OP_PUSH: begin
            if (i == '0) begin
              we       = 1'b1;
              waddr    = '0;
              cnt_next = cnt + 1'b1;
            end else begin
              ren   = 1'b1;
              raddr = AW'(i - 1'b1);
            end
          end
          ropq_pkg::OP_FIRST: begin
            ren   = 1'b1;
            raddr = '0;
          end
          default: begin
            if (at_end) begin
              case (c.op)
                ropq_pkg::OP_FLUSH: cnt_next = w;
                ropq_pkg::OP_POP, ropq_pkg::OP_DELETE: begin
                  if (matched) cnt_next = w;
                  else         res_st_next = ropq_pkg::ST_MISS;
                end
                ropq_pkg::OP_NEXT:
                  res_st_next = matched ? ropq_pkg::ST_NONEXT : ropq_pkg::ST_MISS;
                default: res_st_next = ropq_pkg::ST_MISS;
              endcase
            end else begin
              ren   = 1'b1;
              raddr = i[AW-1:0];
            end
          end
        endcase
      end
      ropq_pkg::S_EV: begin
        case (c.op)
          ropq_pkg::OP_PUSH: begin
            // shift the larger entry up one slot, or drop the new one in
            we    = 1'b1;
            waddr = i[AW-1:0];
            if (gt) begin
              wdata  = rdata;
              i_next = i - 1'b1;
            end else begin
              cnt_next = cnt + 1'b1;
            end
          end
          ropq_pkg::OP_FIRST: res_rr_next = rdata.rank;
          ropq_pkg::OP_FLUSH: begin
            if (rdata.dev != c.dev) begin
              we     = 1'b1;
              waddr  = w[AW-1:0];
              wdata  = rdata;
              w_next = w + 1'b1;
            end
            i_next = i + 1'b1;
          end
          ropq_pkg::OP_POP, ropq_pkg::OP_DELETE: begin
            if (!matched && eq) begin
              matched_next = 1'b1;
              if (c.op == ropq_pkg::OP_POP) res_fh_next = rdata.handle;
            end else begin
              we     = 1'b1;
              waddr  = w[AW-1:0];
              wdata  = rdata;
              w_next = w + 1'b1;
            end
            i_next = i + 1'b1;
          end
          ropq_pkg::OP_LOOKUP: begin
            if (eq) res_fh_next = rdata.handle;
            i_next = i + 1'b1;
          end
          ropq_pkg::OP_NEXT: begin
            if (matched)  res_rr_next  = rdata.rank;
            else if (eq)  matched_next = 1'b1;
            i_next = i + 1'b1;
          end
          default: i_next = i + 1'b1;
        endcase
      end
      ropq_pkg::S_DONE: begin
        if (out_free) load_out = 1'b1;
      end
      default: ;
    endcase
    if (load_out)                   ovalid_next = 1'b1;
    else if (out_valid && out_ready) ovalid_next = 1'b0;
    else                            ovalid_next = out_valid;
  end

  // entry memory, registered read
  always_ff @(posedge clk) begin
    if (we)  mem[waddr] <= wdata;
    if (ren) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    c       <= c_next;
    i       <= i_next;
    w       <= w_next;
    matched <= matched_next;
    res_st  <= res_st_next;
    res_fh  <= res_fh_next;
    res_rr  <= res_rr_next;
    if (load_out) begin
      status       <= res_st;
      found_handle <= 16'(res_fh);
      result_rank  <= res_rr;
      occupancy    <= 9'(cnt);
    end
    if (rst) begin
      state     <= ropq_pkg::S_IDLE;
      cnt       <= '0;
      cap       <= ropq_pkg::CAP_W'(256);
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      out_valid <= ovalid_next;
      if (cfg_we) cap <= cfg_data;
    end
  end
endmodule

>>> rtl/rank_ordered_packet_queue_unit.sv
// top level of the rank ordered packet queue
// depends on ropq_pkg, ropq_front, ropq_back
`timescale 1ns / 1ps
// usage
//   input channel (in_valid/in_ready) takes one word: mode, device_flush, rank,
//   handle, device_id; device_flush set makes it a flush of device_id
//   output channel (out_valid/out_ready) returns one word per input word:
//   status, found_handle, result_rank, occupancy, in input order
//   cfg_we/cfg_data write the capacity register in the same cycle, no wait
// operation, from input accept to result valid
//   a two-word command queue sits between the front decoder and the sequencer,
//   so words are taken while the sequencer is busy or a result is waiting
//   the sequencer walks the single entry memory, reading each entry touched
//   and then evaluating/writing it, as that memory has one read port
//   push: walks down past the stored entries ranked above the new one,
//   shifting each up one slot, then drops the new entry in
//   pop, delete, flush, search miss: walk all stored entries
//   lookup hit: up to the match; next key: one past it; first key: one entry
//   refused push, empty first key, unused mode: no memory access
// reset
//   rst (sync, active high) empties the store, clears the queue and output,
//   and sets capacity to 256; no clearing pass is needed
// stall
//   a held result keeps the sequencer waiting; the queue takes up to two more words
module rank_ordered_packet_queue_unit (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  mode,
  input  logic        device_flush,
  input  logic [63:0] rank,
  input  logic [15:0] handle,
  input  logic [7:0]  device_id,
  input  logic        cfg_we,
  input  logic [8:0]  cfg_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  status,
  output logic [15:0] found_handle,
  output logic [63:0] result_rank,
  output logic [8:0]  occupancy
);
  logic           cmd_valid, cmd_take;
  ropq_pkg::cmd_t cmd;

  // decode and buffer incoming words
  ropq_front u_front (
    .clk, .rst, .in_valid, .in_ready, .mode, .device_flush, .rank, .handle,
    .device_id, .cmd_valid, .cmd_take, .cmd
  );

  // sequencer, entry store and result register
  ropq_back u_back (
    .clk, .rst, .cfg_we, .cfg_data, .cmd_valid, .cmd_take, .cmd,
    .out_valid, .out_ready, .status, .found_handle, .result_rank, .occupancy
  );
endmodule

>>> rtl/ropq_checker.sv
// port-level checks of the rank ordered packet queue, bound to the top level
// depends on assert_macros.svh and ropq_pkg
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ropq_checker (
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  status,
  input logic [15:0] found_handle,
  input logic [63:0] result_rank,
  input logic [8:0]  occupancy
);
  logic no_data;
  assign no_data = (found_handle == '0) && (result_rank == '0);

  `AST_IMPL(a_occ_range, out_valid, occupancy <= 9'd256)
  `AST_IMPL(a_full_clean, out_valid && status == ropq_pkg::ST_FULL, no_data)
  `AST_IMPL(a_handle_ok, out_valid && found_handle != 16'd0, status == ropq_pkg::ST_OK)
  `AST_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(result_rank) && $stable(status))
  `AST_ALWAYS(a_reset_clear, rst, !out_valid)
endmodule

bind rank_ordered_packet_queue_unit ropq_checker u_chk (.*);
